// ===== sv/cetq_pkg.sv =====
// ----------------------------------------------------------------------------
// Countdown event timer queue package
// Shared widths, codes and cell types of the timer queue.
// ----------------------------------------------------------------------------
package cetq_pkg;

    // Number of cells in the chain, one pending event per cell.
    localparam int CAPACITY = 16;

    localparam int CNT_W  = 16;
    localparam int ID_W   = 16;
    localparam int OP_W   = 2;
    localparam int KIND_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_IDLE    = 3'd4
    } t_kind;

    // One list entry. The kill flag marks an entry that leaves the list
    // during the squeeze that follows a remove or a tick.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0]  id;
        logic             valid;
        logic             kill;
    } t_entry;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic mark_rm;
        logic mark_tick;
        logic shift;
    } t_cell_cmd;

endpackage

// ===== sv/cetq_if.sv =====
// ----------------------------------------------------------------------------
// Timer queue channel interfaces
// Valid/ready channels for command words in and result words out.
// ----------------------------------------------------------------------------
interface cetq_in_if import cetq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CNT_W-1:0]  delay;
    logic [ID_W-1:0]   event_id;

    modport source (output valid, operation, delay, event_id, input ready);
    modport sink   (input valid, operation, delay, event_id, output ready);
endinterface

interface cetq_out_if import cetq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic              last;

    modport source (output valid, kind, fired_id, last, input ready);
    modport sink   (input valid, kind, fired_id, last, output ready);
endinterface

// ===== sv/countdown_event_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// Countdown event timer queue
// Sorted list of pending timed events kept in a chain of cells.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Word
//  i_cmd     in         valid / ready      operation, delay, event_id
//  o_res     out        valid / ready      kind, fired_id, last
//
// The block works on one command word at a time. An accepted word is
// latched first and then carried out; an add ends once the result slot is
// free. A remove or a tick first marks the leaving entries in all cells at
// once, then the chain squeezes out one marked entry per cycle (on a tick,
// only while the result slot is free) until none is left, and then answers.
// Reset is synchronous and active low; it empties the list at once.
// A stalled result word holds back an add and the firing of a tick until
// the sink takes it; the squeeze of a remove goes on regardless.
//
module countdown_event_timer_queue_top import cetq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    cetq_in_if.sink    i_cmd,
    cetq_out_if.source o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SQUEEZE,
        S_FIRE
    } t_state;

    t_state r_state, n_state;

    // Latched command word.
    t_op              r_op;
    logic [CNT_W-1:0] r_delay;
    logic [ID_W-1:0]  r_id;

    // Whether the current tick has fired anything yet.
    logic r_fired, n_fired;

    // Output register.
    logic              r_o_valid;
    logic [KIND_W-1:0] r_o_kind;
    logic [ID_W-1:0]   r_o_id;
    logic              r_o_last;

    // Cell chain.
    t_entry    w_entry [CAPACITY];
    logic      w_at    [CAPACITY];
    logic      w_pre   [CAPACITY];
    logic      w_first [CAPACITY];
    logic      w_more  [CAPACITY];
    t_cell_cmd w_cmd;

    logic              w_any_kill;
    logic              w_more_kill;
    logic              w_full;
    logic [ID_W-1:0]   w_first_id;
    logic [CAPACITY-1:0] w_valid_vec;

    logic              w_slot_free;
    logic              w_emit;
    t_kind             w_kind;
    logic [ID_W-1:0]   w_emit_id;
    logic              w_emit_last;
    logic              w_in_acc;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_at;
            logic   w_left_pre;

            if (g == 0) begin : g_head
                assign w_left     = '0;
                assign w_left_at  = 1'b0;
                assign w_left_pre = 1'b0;
            end else begin : g_body
                assign w_left     = w_entry[g-1];
                assign w_left_at  = w_at[g-1];
                assign w_left_pre = w_pre[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            cetq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_delay    (r_delay),
                .i_id       (r_id),
                .i_left     (w_left),
                .i_left_at  (w_left_at),
                .i_left_pre (w_left_pre),
                .i_right    (w_right),
                .o_entry    (w_entry[g]),
                .o_at       (w_at[g]),
                .o_pre      (w_pre[g]),
                .o_first    (w_first[g]),
                .o_more     (w_more[g])
            );
        end
    endgenerate

    // The list is packed, so the tail cell tells whether it is full, and the
    // prefix chain out of the tail tells whether any marked entry is left.
    assign w_full     = w_entry[CAPACITY-1].valid;
    assign w_any_kill = w_pre[CAPACITY-1];

    always_comb begin
        w_first_id  = '0;
        w_more_kill = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_first_id     = w_first_id | (w_first[i] ? w_entry[i].id : '0);
            w_more_kill    = w_more_kill | w_more[i];
            w_valid_vec[i] = w_entry[i].valid;
        end
    end

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign w_in_acc       = i_cmd.valid && i_cmd.ready;
    assign w_slot_free    = !r_o_valid || o_res.ready;

    assign o_res.valid    = r_o_valid;
    assign o_res.kind     = r_o_kind;
    assign o_res.fired_id = r_o_id;
    assign o_res.last     = r_o_last;

    // Controller: decides the cell command and the result word of this cycle.
    always_comb begin
        n_state     = r_state;
        n_fired     = r_fired;
        w_cmd       = '0;
        w_emit      = 1'b0;
        w_kind      = KIND_ADDED;
        w_emit_id   = r_id;
        w_emit_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ADD: begin
                        if (w_slot_free) begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_full) begin
                                w_kind = KIND_FULL;
                            end else begin
                                w_kind       = KIND_ADDED;
                                w_cmd.insert = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        w_cmd.mark_rm = 1'b1;
                        n_state       = S_SQUEEZE;
                    end
                    OP_TICK: begin
                        w_cmd.mark_tick = 1'b1;
                        n_fired         = 1'b0;
                        n_state         = S_FIRE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SQUEEZE: begin
                if (w_any_kill) begin
                    w_cmd.shift = 1'b1;
                end else if (w_slot_free) begin
                    w_emit  = 1'b1;
                    w_kind  = KIND_REMOVED;
                    n_state = S_IDLE;
                end
            end
            S_FIRE: begin
                if (w_any_kill) begin
                    if (w_slot_free) begin
                        // The first marked entry fires and leaves the list.
                        w_cmd.shift = 1'b1;
                        w_emit      = 1'b1;
                        w_kind      = KIND_FIRED;
                        w_emit_id   = w_first_id;
                        w_emit_last = !w_more_kill;
                        n_fired     = 1'b1;
                    end
                end else if (r_fired) begin
                    n_state = S_IDLE;
                end else if (w_slot_free) begin
                    w_emit  = 1'b1;
                    w_kind  = KIND_IDLE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fired   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fired <= n_fired;
            if (w_in_acc) begin
                r_op    <= t_op'(i_cmd.operation);
                r_delay <= i_cmd.delay;
                r_id    <= i_cmd.event_id;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
                r_o_kind  <= w_kind;
                r_o_id    <= w_emit_id;
                r_o_last  <= w_emit_last;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // The occupied cells always form one run starting at the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec + 1'b1) & w_valid_vec) == '0)
        else $error("timer queue list is not packed");

    // No entry stays marked once the block is back waiting for a command.
    a_no_kill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_any_kill)
        else $error("marked entry left in timer queue while idle");

    // An accepted command reaches the execute state in the very next cycle.
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted command not executed");

endmodule

// ===== sv/cetq_cell.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell
// Holds one list entry; inserts, marks and squeezes with its neighbors.
// ----------------------------------------------------------------------------
module cetq_cell import cetq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [CNT_W-1:0] i_delay,
    input  logic [ID_W-1:0]  i_id,
    input  t_entry           i_left,
    input  logic             i_left_at,
    input  logic             i_left_pre,
    input  t_entry           i_right,
    output t_entry           o_entry,
    output logic             o_at,
    output logic             o_pre,
    output logic             o_first,
    output logic             o_more
);

    t_entry r_entry;
    t_entry n_entry;

    // The new event belongs at or before this cell.
    assign o_at    = !r_entry.valid || (i_delay >= r_entry.count);
    // Some kill lies at or before this cell.
    assign o_pre   = r_entry.kill || i_left_pre;
    assign o_first = r_entry.kill && !i_left_pre;
    assign o_more  = r_entry.kill && i_left_pre;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert) begin
            if (i_left_at) begin
                n_entry      = i_left;
                n_entry.kill = 1'b0;
            end else if (o_at) begin
                n_entry.count = i_delay;
                n_entry.id    = i_id;
                n_entry.valid = 1'b1;
                n_entry.kill  = 1'b0;
            end
        end else if (i_cmd.mark_rm) begin
            n_entry.kill = r_entry.valid && (r_entry.id == i_id);
        end else if (i_cmd.mark_tick) begin
            n_entry.kill = r_entry.valid && (r_entry.count == '0);
            if (r_entry.valid && (r_entry.count != '0)) begin
                n_entry.count = r_entry.count - 1'b1;
            end
        end else if (i_cmd.shift) begin
            if (o_pre) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_entry.kill  <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== tb/tb_countdown_event_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// Countdown event timer queue testbench
// Drives add, remove and tick words into the timer queue, predicts the
// sorted event list alongside it and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_countdown_event_timer_queue_top import cetq_pkg::*; ();

    // Operation code 3 has no meaning. The block must drop such a word
    // without a result and without touching the list.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Settling time after the last expected result, long enough to cover a
    // tick that fires a full list and so any straggler.
    localparam int DRAIN_CYCLES = 60;

    // One result word as the block should produce it.
    typedef struct {
        t_kind           kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_result_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cetq_in_if  cmd_if ();
    cetq_out_if res_if ();

    countdown_event_timer_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the event list. Slots 0 .. list_len-1 hold the pending
    // events in list order, largest remaining count first.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] list_cnt [CAPACITY];
    logic [ID_W-1:0]  list_id  [CAPACITY];
    int               list_len = 0;

    // Result words still owed by the block, oldest first.
    t_result_word owed_results [$];

    int n_errors      = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // A test writes a cycle count here to make the result sink hold off.
    // The sink process takes the request over and counts it down itself.
    int sink_hold_req = 0;
    int sink_hold_left = 0;

    // Applies one accepted command word to the shadow list and queues the
    // result words that it must cause. Only the final word carries last.
    function automatic void predict_command(input logic [OP_W-1:0] op,
                                            input logic [CNT_W-1:0] dly,
                                            input logic [ID_W-1:0] id);
        t_result_word words [$];
        t_result_word w;
        int           pos;
        int           keep;
        bit           found;

        w.last = 1'b0;
        case (op)
            OP_ADD: begin
                w.id = id;
                if (list_len >= CAPACITY) begin
                    w.kind = KIND_FULL;
                end else begin
                    // The new event goes ahead of the first entry whose
                    // count is at most its delay, so it also goes ahead of
                    // entries with an equal count.
                    pos   = list_len;
                    found = 1'b0;
                    for (int i = 0; i < list_len; i++) begin
                        if (!found && dly >= list_cnt[i]) begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = list_len; i > pos; i--) begin
                        list_cnt[i] = list_cnt[i-1];
                        list_id[i]  = list_id[i-1];
                    end
                    list_cnt[pos] = dly;
                    list_id[pos]  = id;
                    list_len++;
                    w.kind = KIND_ADDED;
                end
                words = {words, w};
            end
            OP_REMOVE: begin
                // Every entry with this identifier leaves; a remove with no
                // match still answers with one word.
                keep = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_id[i] != id) begin
                        list_cnt[keep] = list_cnt[i];
                        list_id[keep]  = list_id[i];
                        keep++;
                    end
                end
                list_len = keep;
                w.kind   = KIND_REMOVED;
                w.id     = id;
                words = {words, w};
            end
            OP_TICK: begin
                // Entries at zero fire in list order; the rest count down.
                keep = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_cnt[i] == '0) begin
                        w.kind = KIND_FIRED;
                        w.id   = list_id[i];
                        words = {words, w};
                    end else begin
                        list_cnt[keep] = list_cnt[i] - 1'b1;
                        list_id[keep]  = list_id[i];
                        keep++;
                    end
                end
                list_len = keep;
                if (words.size() == 0) begin
                    w.kind = KIND_IDLE;
                    w.id   = id;
                    words = {words, w};
                end
            end
            default: begin
            end
        endcase

        if (words.size() != 0) begin
            words[words.size()-1].last = 1'b1;
        end
        owed_results = {owed_results, words};
    endfunction

    // Offers one command word and returns at the falling edge after it was
    // taken. The caller is always at a falling edge, and valid is left high
    // so that back-to-back words need no extra assignment in one step.
    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic [CNT_W-1:0] dly,
                                input logic [ID_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.delay     <= dly;
        cmd_if.event_id  <= id;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        predict_command(op, dly, id);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed result word has come back.
    // At least one falling edge passes, so the next word never lowers and
    // raises valid in the same step.
    task automatic wait_results_drained();
        cmd_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (owed_results.size() != 0);
    endtask

    // A handful of identifiers that adds and removes share, so that removes
    // find matches. All-zero and all-one identifiers are among them.
    function automatic logic [ID_W-1:0] shared_id(input int unsigned idx);
        case (idx % 8)
            0: shared_id = 16'h0000;
            1: shared_id = 16'hFFFF;
            2: shared_id = 16'h00FF;
            3: shared_id = 16'hFF00;
            4: shared_id = 16'h0F0F;
            5: shared_id = 16'hF0F0;
            6: shared_id = 16'h1234;
            default: shared_id = 16'hC3C3;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result sink. Ready changes at the falling edge: either a long hold-off
    // requested by a test, or a random stall at the current idle rate.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold_req != 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left != 0) begin
            res_if.ready <= 1'b0;
            sink_hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Each word taken at a rising edge is compared with the oldest owed one.
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (owed_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result word: kind %0d id %h last %b",
                         $time, res_if.kind, res_if.fired_id, res_if.last);
            end else begin
                want = owed_results.pop_front();
                if (res_if.kind !== want.kind) begin
                    n_errors++;
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, res_if.kind);
                end
                if (res_if.fired_id !== want.id) begin
                    n_errors++;
                    $display("%0t: fired_id mismatch: expected %h, actual %h",
                             $time, want.id, res_if.fired_id);
                end
                if (res_if.last !== want.last) begin
                    n_errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, res_if.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // On an empty list a tick fires nothing, a remove finds nothing, and the
    // unused operation code must be swallowed without a result.
    task automatic test_empty_list();
        send_command(OP_TICK, 16'h0000, 16'hFFFF);
        send_command(OP_REMOVE, 16'hFFFF, 16'h0000);
        send_command(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send_command(OP_TICK, 16'hFFFF, 16'h0000);
    endtask

    // Fills all cells with extreme delays and identifiers, equal counts and
    // a repeated identifier, then adds once more to a full list.
    task automatic test_fill_to_capacity();
        send_command(OP_ADD, 16'd5,    16'h0000);
        send_command(OP_ADD, 16'hFFFF, 16'hFFFF);
        send_command(OP_ADD, 16'd5,    16'h1234);
        send_command(OP_ADD, 16'd0,    16'hA5A5);
        send_command(OP_ADD, 16'd0,    16'h5A5A);
        send_command(OP_ADD, 16'd1,    16'h0001);
        send_command(OP_ADD, 16'hFFFF, 16'h0002);
        send_command(OP_ADD, 16'd3,    16'h1234);
        send_command(OP_ADD, 16'd0,    16'h0003);
        send_command(OP_ADD, 16'd2,    16'h0004);
        send_command(OP_ADD, 16'd0,    16'h0005);
        send_command(OP_ADD, 16'd7,    16'h1234);
        send_command(OP_ADD, 16'd0,    16'h0006);
        send_command(OP_ADD, 16'd4,    16'h0007);
        send_command(OP_ADD, 16'd0,    16'h0008);
        send_command(OP_ADD, 16'h8000, 16'h0009);
        // The list is full now, so this one is turned away.
        send_command(OP_ADD, 16'd9,    16'hBEEF);
    endtask

    // Removes an identifier held three times, ticks twice so that the zero-count
    // entries fire as a group and then one more alone, then removes all-ones.
    task automatic test_remove_and_tick();
        send_command(OP_REMOVE, 16'h0000, 16'h1234);
        send_command(OP_TICK,   16'h0000, 16'h0000);
        send_command(OP_TICK,   16'h0000, 16'h0000);
        send_command(OP_REMOVE, 16'h0000, 16'hFFFF);
    endtask

    // Empties the list, then holds the sink off for a long stretch while
    // the sender keeps offering adds, so the block stalls on its input. A
    // full list of zero-count events then all fires on one tick.
    task automatic test_backpressure_burst();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_results_drained();
        while (list_len != 0) begin
            send_command(OP_REMOVE, 16'h0000, list_id[0]);
        end
        sink_hold_req = 300;
        for (int i = 0; i < CAPACITY; i++) begin
            send_command(OP_ADD, 16'h0000, 16'h0100 + i[ID_W-1:0]);
        end
        send_command(OP_ADD, 16'h0000, 16'hDEAD);
        send_command(OP_TICK, 16'h0000, 16'h0000);
        // The sender pauses here until every owed word has come back.
        wait_results_drained();
    endtask

    // Random traffic: adds, mostly with short delays, and ticks that drain
    // them, removes on shared identifiers, a few long or extreme delays and
    // now and then the unused operation code.
    task automatic test_random_traffic(input int n_words, input int src_pct,
                                       input int sink_pct);
        int unsigned      roll;
        int unsigned      span;
        logic [CNT_W-1:0] dly;
        logic [ID_W-1:0]  id;

        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < n_words; n++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                span = $urandom_range(19);
                if (span < 15) begin
                    dly = CNT_W'($urandom_range(6));
                end else if (span < 18) begin
                    dly = CNT_W'($urandom_range(40, 7));
                end else if (span == 18) begin
                    dly = CNT_W'($urandom_range(16'hFFFF));
                end else begin
                    dly = 16'hFFFF;
                end
                // Long-lived events take shared identifiers so that a later
                // remove can clear them and the list does not clog.
                if (dly > 16'd40 || $urandom_range(9) < 7) begin
                    id = shared_id($urandom_range(7));
                end else begin
                    id = ID_W'($urandom_range(16'hFFFF));
                end
                send_command(OP_ADD, dly, id);
            end else if (roll < 78) begin
                send_command(OP_TICK, CNT_W'($urandom_range(16'hFFFF)),
                             ID_W'($urandom_range(16'hFFFF)));
            end else if (roll < 95) begin
                if ($urandom_range(99) < 85) begin
                    id = shared_id($urandom_range(7));
                end else begin
                    id = ID_W'($urandom_range(16'hFFFF));
                end
                send_command(OP_REMOVE, CNT_W'($urandom_range(16'hFFFF)), id);
            end else begin
                send_command(OP_UNUSED, CNT_W'($urandom_range(16'hFFFF)),
                             ID_W'($urandom_range(16'hFFFF)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_ADD;
        cmd_if.delay     = '0;
        cmd_if.event_id  = '0;
        res_if.ready     = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_fill_to_capacity();
        test_remove_and_tick();
        test_backpressure_burst();
        test_random_traffic(150, 36, 81);
        test_random_traffic(150, 81, 36);
        test_random_traffic(150, 0, 0);

        // A trailing unused code leaves no result to wait for, so give the
        // block its full latency before judging the run.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && owed_results.size() == 0) begin
            $display("countdown_event_timer_queue_top regression: pass");
        end else begin
            if (owed_results.size() != 0) begin
                $display("%0t: %0d result words never arrived",
                         $time, owed_results.size());
            end
            $display("countdown_event_timer_queue_top regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the sequence above.
    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d result words outstanding",
                 $time, owed_results.size());
        $display("countdown_event_timer_queue_top regression: fail");
        $finish;
    end

endmodule
